// File: src/gmdfs_pkg.sv
// Shared types, codes and the grid neighbour step for the maze search block.
package gmdfs_pkg;

	// Largest grid side that the 3-bit row and column fields can reach.
	localparam int FIELD_SPAN = 8;

	localparam int DEF_MAX_ROWS = 8;
	localparam int DEF_MAX_COLS = 8;

	// Reset value of both grid size registers.
	localparam logic [3:0] DIM_RESET = 4'd8;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
	localparam logic [1:0] CFG_GRID_COLS = 2'd1;

	// Input item kinds.
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// Result status codes.
	localparam logic STATUS_PATH = 1'b0;
	localparam logic STATUS_NONE = 1'b1;

	// Search directions, tried in this order.
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_S = 2'd1;
	localparam logic [1:0] DIR_W = 2'd2;
	localparam logic [1:0] DIR_E = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [2:0] row;
		logic [2:0] col;
		logic       open;
	} req_t;

	typedef struct packed {
		logic [2:0] path_row;
		logic [2:0] path_col;
		logic       status;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] r;
		logic [2:0] c;
	} nb_t;

	// One step from (r,c) in direction d; ok is low when the step leaves the grid in use.
	function automatic nb_t step_cell(input logic [2:0] r, input logic [2:0] c,
		input logic [1:0] d, input logic [3:0] rows, input logic [3:0] cols);
		nb_t n;
		n.ok = 1'b1;
		n.r  = r;
		n.c  = c;
		case (d)
			DIR_N: begin
				n.ok = (r != 3'd0);
				n.r  = r - 3'd1;
			end
			DIR_S: begin
				n.ok = (({1'b0, r} + 4'd1) < rows);
				n.r  = r + 3'd1;
			end
			DIR_W: begin
				n.ok = (c != 3'd0);
				n.c  = c - 3'd1;
			end
			DIR_E: begin
				n.ok = (({1'b0, c} + 4'd1) < cols);
				n.c  = c + 3'd1;
			end
			default: begin
				n.ok = 1'b0;
			end
		endcase
		return n;
	endfunction

endpackage

// File: src/grid_maze_depth_first_search.sv
// Maze search block: grid store, flood-fill reachability test and backtracking walk.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_ready  gmdfs_pkg::req_t (kind, row, col, open)
//   rsp      out        rsp_valid / rsp_ready  gmdfs_pkg::rsp_t (path_row, path_col, status, last)
//   cfg      in         cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (4 bits)
//
// A search runs the start checks, then a flood fill from the source and one from each free
// non-goal neighbour that the walk tries. The walk tries each direction with a step state
// and, for a step inside the grid, a check state. A flood runs a setup state, then per cell
// a queue pop and per direction a step state and, for a step inside the grid, a check state,
// then a wrap-up state, all through the single neighbour-step unit and the one-port flood
// queue. Emission reads each path cell from the stack and sends it, then the final word.
// Reset blocks every cell through per-cell valid flags; no clearing pass is needed.
// A word waits in the result register while rsp_ready is low; emission stalls behind it.
module grid_maze_depth_first_search #(
	parameter int MAX_ROWS = gmdfs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gmdfs_pkg::DEF_MAX_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  gmdfs_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output gmdfs_pkg::rsp_t   rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data
);

	localparam int EFF_ROWS = (MAX_ROWS < gmdfs_pkg::FIELD_SPAN) ? MAX_ROWS : gmdfs_pkg::FIELD_SPAN;
	localparam int EFF_COLS = (MAX_COLS < gmdfs_pkg::FIELD_SPAN) ? MAX_COLS : gmdfs_pkg::FIELD_SPAN;
	localparam int CELLS    = EFF_ROWS * EFF_COLS;
	localparam int CIW      = $clog2(CELLS);
	localparam int DW       = $clog2(CELLS + 1);
	localparam logic [3:0] EFF_ROWS4 = 4'(EFF_ROWS);
	localparam logic [3:0] EFF_COLS4 = 4'(EFF_COLS);

	typedef struct packed {
		logic [2:0] r;
		logic [2:0] c;
	} pos_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_BFS_INIT,
		ST_BFS_POP,
		ST_BFS_NB,
		ST_BFS_CHK,
		ST_BFS_END,
		ST_DFS_NB,
		ST_DFS_CHK,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMIT_ONE
	} state_t;

	function automatic logic [CIW-1:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
		return CIW'(int'(r) * EFF_COLS + int'(c));
	endfunction

	state_t          state_q;
	logic [3:0]      rows_q, cols_q;
	logic [2:0]      src_r_q, src_c_q;
	logic [2:0]      cur_r_q, cur_c_q;
	logic [2:0]      nb_r_q, nb_c_q;
	logic [1:0]      ddir_q, bdir_q;
	logic            cand_q, reach_q;
	logic [DW-1:0]   depth_q, head_q, tail_q, emit_idx_q;
	logic [2:0]      res_r_q, res_c_q;
	logic            res_st_q;
	logic [CELLS-1:0] gv_q, onpath_q, seen_q;
	logic            rsp_valid_q;
	gmdfs_pkg::rsp_t rsp_q;

	logic            grid_mem_q [CELLS];
	pos_t            queue_mem_q [CELLS];
	pos_t            stack_mem_q [CELLS];
	logic            grid_rd_q, gvr_q;
	logic [CIW-1:0]  nb_idx_q;
	pos_t            q_rd_q, stk_rd_q;

	logic [3:0]      rows_use, cols_use;
	logic [2:0]      goal_r, goal_c;
	logic [2:0]      nu_r, nu_c;
	logic [1:0]      nu_d;
	gmdfs_pkg::nb_t  nb;
	logic [CIW-1:0]  rd_idx, src_idx, gw_idx;
	logic            gw_en, qw_en, sw_en;
	logic [CIW-1:0]  qw_idx, sw_idx;
	pos_t            qw_data;
	logic            src_in, src_goal, free_d, free_b, nb_goal, out_free, rsp_load;

	always_comb begin
		rows_use = (rows_q > EFF_ROWS4) ? EFF_ROWS4 : rows_q;
		cols_use = (cols_q > EFF_COLS4) ? EFF_COLS4 : cols_q;
		goal_r   = 3'(rows_use - 4'd1);
		goal_c   = 3'(cols_use - 4'd1);

		// The neighbour-step unit serves the flood fill and the walk in turn.
		if (state_q == ST_BFS_NB) begin
			nu_r = q_rd_q.r;
			nu_c = q_rd_q.c;
			nu_d = bdir_q;
		end else begin
			nu_r = cur_r_q;
			nu_c = cur_c_q;
			nu_d = ddir_q;
		end
		nb      = gmdfs_pkg::step_cell(nu_r, nu_c, nu_d, rows_use, cols_use);
		rd_idx  = cell_idx(nb.r, nb.c);
		src_idx = cell_idx(src_r_q, src_c_q);

		src_in   = ({1'b0, src_r_q} < rows_use) && ({1'b0, src_c_q} < cols_use);
		src_goal = (src_r_q == goal_r) && (src_c_q == goal_c);
		free_d   = grid_rd_q && gvr_q && !onpath_q[nb_idx_q];
		free_b   = free_d && !seen_q[nb_idx_q];
		nb_goal  = (nb_r_q == goal_r) && (nb_c_q == goal_c);
		out_free = !rsp_valid_q || rsp_ready;
		rsp_load = out_free && (state_q == ST_EMIT_OUT || state_q == ST_EMIT_ONE);

		gw_en  = req_valid && req_ready && (req.kind == gmdfs_pkg::KIND_WRITE)
			&& ({1'b0, req.row} < EFF_ROWS4) && ({1'b0, req.col} < EFF_COLS4);
		gw_idx = cell_idx(req.row, req.col);

		qw_en   = 1'b0;
		qw_idx  = '0;
		qw_data = '{r: src_r_q, c: src_c_q};
		if (state_q == ST_BFS_INIT) begin
			qw_en = 1'b1;
		end else if (state_q == ST_BFS_CHK && free_b && !nb_goal) begin
			qw_en   = 1'b1;
			qw_idx  = tail_q[CIW-1:0];
			qw_data = '{r: nb_r_q, c: nb_c_q};
		end

		sw_en  = 1'b0;
		sw_idx = '0;
		if (state_q == ST_START && src_in && !src_goal) begin
			sw_en = 1'b1;
		end else if (state_q == ST_BFS_END && reach_q && cand_q) begin
			sw_en  = 1'b1;
			sw_idx = depth_q[CIW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (gw_en) begin
			grid_mem_q[gw_idx] <= req.open;
		end
		grid_rd_q <= grid_mem_q[rd_idx];
		gvr_q     <= gv_q[rd_idx];
		nb_idx_q  <= rd_idx;
	end

	always_ff @(posedge clk) begin
		if (qw_en) begin
			queue_mem_q[qw_idx] <= qw_data;
		end
		if (state_q == ST_BFS_POP) begin
			q_rd_q <= queue_mem_q[head_q[CIW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (sw_en) begin
			stack_mem_q[sw_idx] <= '{r: src_r_q, c: src_c_q};
		end
		if (state_q == ST_EMIT_RD) begin
			stk_rd_q <= stack_mem_q[emit_idx_q[CIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= gmdfs_pkg::DIM_RESET;
			cols_q      <= gmdfs_pkg::DIM_RESET;
			src_r_q     <= '0;
			src_c_q     <= '0;
			cur_r_q     <= '0;
			cur_c_q     <= '0;
			nb_r_q      <= '0;
			nb_c_q      <= '0;
			ddir_q      <= gmdfs_pkg::DIR_N;
			bdir_q      <= gmdfs_pkg::DIR_N;
			cand_q      <= 1'b0;
			reach_q     <= 1'b0;
			depth_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			emit_idx_q  <= '0;
			res_r_q     <= '0;
			res_c_q     <= '0;
			res_st_q    <= gmdfs_pkg::STATUS_PATH;
			gv_q        <= '0;
			onpath_q    <= '0;
			seen_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					gmdfs_pkg::CFG_GRID_ROWS: rows_q <= cfg_data;
					gmdfs_pkg::CFG_GRID_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (gw_en) begin
				gv_q[gw_idx] <= 1'b1;
			end
			if (rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid && req.kind == gmdfs_pkg::KIND_SEARCH) begin
						src_r_q <= req.row;
						src_c_q <= req.col;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (!src_in) begin
						res_r_q  <= '0;
						res_c_q  <= '0;
						res_st_q <= gmdfs_pkg::STATUS_NONE;
						state_q  <= ST_EMIT_ONE;
					end else if (src_goal) begin
						res_r_q  <= src_r_q;
						res_c_q  <= src_c_q;
						res_st_q <= gmdfs_pkg::STATUS_PATH;
						state_q  <= ST_EMIT_ONE;
					end else begin
						onpath_q <= CELLS'(1) << src_idx;
						depth_q  <= DW'(1);
						cur_r_q  <= src_r_q;
						cur_c_q  <= src_c_q;
						cand_q   <= 1'b0;
						state_q  <= ST_BFS_INIT;
					end
				end
				ST_BFS_INIT: begin
					seen_q  <= CELLS'(1) << src_idx;
					head_q  <= '0;
					tail_q  <= DW'(1);
					state_q <= ST_BFS_POP;
				end
				ST_BFS_POP: begin
					if (head_q == tail_q) begin
						reach_q <= 1'b0;
						state_q <= ST_BFS_END;
					end else begin
						head_q  <= head_q + DW'(1);
						bdir_q  <= gmdfs_pkg::DIR_N;
						state_q <= ST_BFS_NB;
					end
				end
				ST_BFS_NB: begin
					nb_r_q <= nb.r;
					nb_c_q <= nb.c;
					if (nb.ok) begin
						state_q <= ST_BFS_CHK;
					end else if (bdir_q == gmdfs_pkg::DIR_E) begin
						state_q <= ST_BFS_POP;
					end else begin
						bdir_q <= bdir_q + 2'd1;
					end
				end
				ST_BFS_CHK: begin
					if (free_b && nb_goal) begin
						reach_q <= 1'b1;
						state_q <= ST_BFS_END;
					end else begin
						if (free_b) begin
							seen_q[nb_idx_q] <= 1'b1;
							tail_q           <= tail_q + DW'(1);
						end
						if (bdir_q == gmdfs_pkg::DIR_E) begin
							state_q <= ST_BFS_POP;
						end else begin
							bdir_q  <= bdir_q + 2'd1;
							state_q <= ST_BFS_NB;
						end
					end
				end
				ST_BFS_END: begin
					if (!cand_q) begin
						if (reach_q) begin
							ddir_q  <= gmdfs_pkg::DIR_N;
							state_q <= ST_DFS_NB;
						end else begin
							res_r_q  <= '0;
							res_c_q  <= '0;
							res_st_q <= gmdfs_pkg::STATUS_NONE;
							state_q  <= ST_EMIT_ONE;
						end
					end else if (reach_q) begin
						// The candidate can still reach the goal: step into it.
						onpath_q[src_idx] <= 1'b1;
						depth_q           <= depth_q + DW'(1);
						cur_r_q           <= src_r_q;
						cur_c_q           <= src_c_q;
						ddir_q            <= gmdfs_pkg::DIR_N;
						state_q           <= ST_DFS_NB;
					end else if (ddir_q == gmdfs_pkg::DIR_E) begin
						res_r_q  <= '0;
						res_c_q  <= '0;
						res_st_q <= gmdfs_pkg::STATUS_NONE;
						state_q  <= ST_EMIT_ONE;
					end else begin
						ddir_q  <= ddir_q + 2'd1;
						state_q <= ST_DFS_NB;
					end
				end
				ST_DFS_NB: begin
					nb_r_q <= nb.r;
					nb_c_q <= nb.c;
					if (nb.ok) begin
						state_q <= ST_DFS_CHK;
					end else if (ddir_q == gmdfs_pkg::DIR_E) begin
						res_r_q  <= '0;
						res_c_q  <= '0;
						res_st_q <= gmdfs_pkg::STATUS_NONE;
						state_q  <= ST_EMIT_ONE;
					end else begin
						ddir_q <= ddir_q + 2'd1;
					end
				end
				ST_DFS_CHK: begin
					if (free_d && nb_goal) begin
						res_r_q    <= nb_r_q;
						res_c_q    <= nb_c_q;
						res_st_q   <= gmdfs_pkg::STATUS_PATH;
						emit_idx_q <= '0;
						state_q    <= ST_EMIT_RD;
					end else if (free_d) begin
						src_r_q <= nb_r_q;
						src_c_q <= nb_c_q;
						cand_q  <= 1'b1;
						state_q <= ST_BFS_INIT;
					end else if (ddir_q == gmdfs_pkg::DIR_E) begin
						res_r_q  <= '0;
						res_c_q  <= '0;
						res_st_q <= gmdfs_pkg::STATUS_NONE;
						state_q  <= ST_EMIT_ONE;
					end else begin
						ddir_q  <= ddir_q + 2'd1;
						state_q <= ST_DFS_NB;
					end
				end
				ST_EMIT_RD: begin
					emit_idx_q <= emit_idx_q + DW'(1);
					state_q    <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{path_row: stk_rd_q.r, path_col: stk_rd_q.c,
							status: gmdfs_pkg::STATUS_PATH, last: 1'b0};
						state_q     <= (emit_idx_q == depth_q) ? ST_EMIT_ONE : ST_EMIT_RD;
					end
				end
				ST_EMIT_ONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{path_row: res_r_q, path_col: res_c_q,
							status: res_st_q, last: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A no-path word always closes its search.
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == gmdfs_pkg::STATUS_NONE |-> rsp.last)
		else $error("no-path word without last flag");

	// The path flags and the stack depth move together during the walk.
	a_path_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DFS_NB || state_q == ST_DFS_CHK |-> $countones(onpath_q) == int'(depth_q))
		else $error("path flags disagree with stack depth");

	// The flood queue never runs past its tail or its capacity.
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BFS_POP || state_q == ST_BFS_NB || state_q == ST_BFS_CHK
		|-> head_q <= tail_q && int'(tail_q) <= CELLS)
		else $error("flood queue pointers out of range");

	// Every emitted stack word comes from a pushed entry.
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_OUT |-> emit_idx_q != '0 && emit_idx_q <= depth_q)
		else $error("path emission index out of range");

endmodule
